@@ hw/rtl/clipped_color_key_sprite_blitter_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Sprite blitter assertion macros
// Shared concurrent assertion forms used by the blitter checker.
// ----------------------------------------------------------------------------
`ifndef CLIPPED_COLOR_KEY_SPRITE_BLITTER_UNIT_DEFINES_SVH
`define CLIPPED_COLOR_KEY_SPRITE_BLITTER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define CCKSB_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CCKSB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Same-cycle implication that is also checked around reset.
`define CCKSB_ASSERT_IMP_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/ccksb_pkg.sv @@
// ----------------------------------------------------------------------------
// Sprite blitter package
// Types, register codes and constants shared by the blitter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ccksb_pkg;

  localparam int ADDR_W  = 17;
  localparam int COLOR_W = 16;
  localparam int COL_W   = 9;
  localparam int ROW_W   = 8;
  localparam int SX_W    = COL_W + 1;
  localparam int SY_W    = ROW_W + 1;
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  localparam logic [1:0] MODE_OPAQUE = 2'd0;
  localparam logic [1:0] MODE_KEYED  = 2'd1;
  localparam logic [1:0] MODE_LINE   = 2'd2;

  typedef enum logic [2:0] {
    REG_DRAW_MODE   = 3'd0,
    REG_ORIGIN_X    = 3'd1,
    REG_ORIGIN_Y    = 3'd2,
    REG_SPRITE_COLS = 3'd3,
    REG_SPRITE_ROWS = 3'd4,
    REG_KEY_COLOR   = 3'd5,
    REG_RUN_LENGTH  = 3'd6,
    REG_RUN_COLOR   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]         draw_mode;
    logic [COL_W-1:0]   origin_x;
    logic [ROW_W-1:0]   origin_y;
    logic [COL_W-1:0]   sprite_cols;
    logic [ROW_W-1:0]   sprite_rows;
    logic [COLOR_W-1:0] key_color;
    logic [COL_W-1:0]   run_length;
    logic [COLOR_W-1:0] run_color;
  } cfg_t;

  // One drawing step after the position walk, before clipping.
  typedef struct packed {
    logic [SX_W-1:0]    sx;
    logic [SY_W-1:0]    sy;
    logic [COLOR_W-1:0] data;
    logic               keyed_out;
    logic               done;
  } step_t;

endpackage

`default_nettype wire

@@ hw/rtl/ccksb_stream_if.sv @@
// ----------------------------------------------------------------------------
// Sprite blitter channels
// Valid/ready interfaces for the source pixel and framebuffer write items.
// ----------------------------------------------------------------------------
`default_nettype none

interface ccksb_pixel_if;
  logic                         valid;
  logic                         ready;
  logic [ccksb_pkg::COLOR_W-1:0] src_pixel;

  modport source (output valid, output src_pixel, input ready);
  modport sink (input valid, input src_pixel, output ready);
endinterface

interface ccksb_write_if;
  logic                         valid;
  logic                         ready;
  logic                         write_enable;
  logic [ccksb_pkg::ADDR_W-1:0]  write_address;
  logic [ccksb_pkg::COLOR_W-1:0] write_data;
  logic                         draw_done;

  modport source (output valid, output write_enable, output write_address,
                  output write_data, output draw_done, input ready);
  modport sink (input valid, input write_enable, input write_address,
                input write_data, input draw_done, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/ccksb_regs.sv @@
// ----------------------------------------------------------------------------
// Sprite blitter register file
// APB-style configuration registers with read-back and a write strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module ccksb_regs (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ccksb_pkg::PADDR_W-1:0] paddr,
  input  wire logic [ccksb_pkg::PDATA_W-1:0] pwdata,
  output logic      [ccksb_pkg::PDATA_W-1:0] prdata,
  output logic                               pready,
  output ccksb_pkg::cfg_t                    cfg,
  output logic                               cfg_wr
);

  ccksb_pkg::reg_idx_t idx;

  assign pready = 1'b1;
  assign idx    = ccksb_pkg::reg_idx_t'(paddr[ccksb_pkg::PADDR_W-1:2]);
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.draw_mode   <= ccksb_pkg::MODE_OPAQUE;
      cfg.origin_x    <= '0;
      cfg.origin_y    <= '0;
      cfg.sprite_cols <= ccksb_pkg::COL_W'(1);
      cfg.sprite_rows <= ccksb_pkg::ROW_W'(1);
      cfg.key_color   <= '0;
      cfg.run_length  <= ccksb_pkg::COL_W'(1);
      cfg.run_color   <= '0;
    end else if (cfg_wr) begin
      case (idx)
        ccksb_pkg::REG_DRAW_MODE:   cfg.draw_mode   <= pwdata[1:0];
        ccksb_pkg::REG_ORIGIN_X:    cfg.origin_x    <= pwdata[ccksb_pkg::COL_W-1:0];
        ccksb_pkg::REG_ORIGIN_Y:    cfg.origin_y    <= pwdata[ccksb_pkg::ROW_W-1:0];
        ccksb_pkg::REG_SPRITE_COLS: cfg.sprite_cols <= pwdata[ccksb_pkg::COL_W-1:0];
        ccksb_pkg::REG_SPRITE_ROWS: cfg.sprite_rows <= pwdata[ccksb_pkg::ROW_W-1:0];
        ccksb_pkg::REG_KEY_COLOR:   cfg.key_color   <= pwdata[ccksb_pkg::COLOR_W-1:0];
        ccksb_pkg::REG_RUN_LENGTH:  cfg.run_length  <= pwdata[ccksb_pkg::COL_W-1:0];
        ccksb_pkg::REG_RUN_COLOR:   cfg.run_color   <= pwdata[ccksb_pkg::COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      ccksb_pkg::REG_DRAW_MODE:   prdata = ccksb_pkg::PDATA_W'(cfg.draw_mode);
      ccksb_pkg::REG_ORIGIN_X:    prdata = ccksb_pkg::PDATA_W'(cfg.origin_x);
      ccksb_pkg::REG_ORIGIN_Y:    prdata = ccksb_pkg::PDATA_W'(cfg.origin_y);
      ccksb_pkg::REG_SPRITE_COLS: prdata = ccksb_pkg::PDATA_W'(cfg.sprite_cols);
      ccksb_pkg::REG_SPRITE_ROWS: prdata = ccksb_pkg::PDATA_W'(cfg.sprite_rows);
      ccksb_pkg::REG_KEY_COLOR:   prdata = ccksb_pkg::PDATA_W'(cfg.key_color);
      ccksb_pkg::REG_RUN_LENGTH:  prdata = ccksb_pkg::PDATA_W'(cfg.run_length);
      ccksb_pkg::REG_RUN_COLOR:   prdata = ccksb_pkg::PDATA_W'(cfg.run_color);
      default:                    prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/ccksb_walk.sv @@
// ----------------------------------------------------------------------------
// Sprite blitter position walk
// Column and row counters and the input register of the step pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module ccksb_walk (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire ccksb_pkg::cfg_t               cfg,
  input  wire logic                          cfg_wr,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [ccksb_pkg::COLOR_W-1:0] in_pixel,
  output logic                               step_valid,
  input  wire logic                          step_ready,
  output ccksb_pkg::step_t                   step
);

  logic [ccksb_pkg::COL_W-1:0] column_count, column_count_next;
  logic [ccksb_pkg::ROW_W-1:0] row_count, row_count_next;
  logic                        step_valid_next;
  logic                        accept;
  logic                        line_mode;
  logic [ccksb_pkg::COL_W-1:0] cols, len;
  logic [ccksb_pkg::ROW_W-1:0] rows;
  logic [ccksb_pkg::COL_W:0]   col_inc;
  logic [ccksb_pkg::ROW_W:0]   row_inc;
  logic                        last_col, last_row, line_done;
  ccksb_pkg::step_t            step_next;

  assign in_ready  = ~step_valid | step_ready;
  assign accept    = in_valid & in_ready;
  assign line_mode = (cfg.draw_mode == ccksb_pkg::MODE_LINE);

  // A size of zero behaves as one.
  assign cols = (cfg.sprite_cols == '0) ? ccksb_pkg::COL_W'(1) : cfg.sprite_cols;
  assign rows = (cfg.sprite_rows == '0) ? ccksb_pkg::ROW_W'(1) : cfg.sprite_rows;
  assign len  = (cfg.run_length == '0) ? ccksb_pkg::COL_W'(1) : cfg.run_length;

  assign col_inc   = {1'b0, column_count} + (ccksb_pkg::COL_W + 1)'(1);
  assign row_inc   = {1'b0, row_count} + (ccksb_pkg::ROW_W + 1)'(1);
  assign last_col  = (col_inc >= {1'b0, cols});
  assign last_row  = (row_inc >= {1'b0, rows});
  assign line_done = (col_inc >= {1'b0, len});

  always_comb begin
    step_next.sx   = {1'b0, cfg.origin_x} + {1'b0, column_count};
    step_next.sy   = line_mode ? {1'b0, cfg.origin_y}
                               : {1'b0, cfg.origin_y} + {1'b0, row_count};
    step_next.data = line_mode ? cfg.run_color : in_pixel;
    step_next.keyed_out = (cfg.draw_mode == ccksb_pkg::MODE_KEYED) &&
                          (in_pixel == cfg.key_color);
    step_next.done = line_mode ? line_done : (last_col & last_row);

    column_count_next = column_count;
    row_count_next    = row_count;
    if (cfg_wr) begin
      column_count_next = '0;
      row_count_next    = '0;
    end else if (accept) begin
      if (line_mode) begin
        column_count_next = line_done ? '0 : col_inc[ccksb_pkg::COL_W-1:0];
        row_count_next    = '0;
      end else if (last_col) begin
        column_count_next = '0;
        row_count_next    = last_row ? '0 : row_inc[ccksb_pkg::ROW_W-1:0];
      end else begin
        column_count_next = col_inc[ccksb_pkg::COL_W-1:0];
      end
    end

    if (accept) begin
      step_valid_next = 1'b1;
    end else if (step_ready) begin
      step_valid_next = 1'b0;
    end else begin
      step_valid_next = step_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      step_valid   <= 1'b0;
    end else begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
      step_valid   <= step_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      step <= step_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ccksb_emit.sv @@
// ----------------------------------------------------------------------------
// Sprite blitter write stage
// Clips a step, forms the linear address and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ccksb_emit #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 240
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           step_valid,
  output logic                                step_ready,
  input  wire ccksb_pkg::step_t               step,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                write_enable,
  output logic      [ccksb_pkg::ADDR_W-1:0]   write_address,
  output logic      [ccksb_pkg::COLOR_W-1:0]  write_data,
  output logic                                draw_done
);

  logic        load;
  logic        out_valid_next;
  logic        on_screen;
  logic        we;
  logic [31:0] addr_full;

  assign step_ready = ~out_valid | out_ready;
  assign load       = step_valid & step_ready;

  assign on_screen = (32'(step.sx) < 32'(SCREEN_WIDTH)) &&
                     (32'(step.sy) < 32'(SCREEN_HEIGHT));
  assign we        = on_screen & ~step.keyed_out;
  assign addr_full = 32'(step.sy) * 32'(SCREEN_WIDTH) + 32'(step.sx);

  always_comb begin
    if (load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  // Suppressed writes carry a zero address and zero data.
  always_ff @(posedge clk) begin
    if (load) begin
      write_enable  <= we;
      write_address <= we ? addr_full[ccksb_pkg::ADDR_W-1:0] : '0;
      write_data    <= we ? step.data : '0;
      draw_done     <= step.done;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/clipped_color_key_sprite_blitter_unit.sv @@
// ----------------------------------------------------------------------------
// Clipped color-key sprite blitter
// Turns a stream of sprite pixels or line steps into framebuffer writes.
// ----------------------------------------------------------------------------
//
//   Channel   Kind        Direction  Carries
//   --------  ----------  ---------  ------------------------------------------
//   pixel     valid/rdy   in         src_pixel, one source pixel per item
//   fb_write  valid/rdy   out        write_enable, write_address, write_data,
//                                    draw_done, one result per item
//   APB       psel/pen    in/out     eight configuration registers at 4*i
//
// The block takes one item per cycle while fb_write does not stall, and passes
// each item through the position walk register, then the result register.
// The rate is set by the column/row counter update, which is one increment
// and compare per cycle. A stalled fb_write holds the result register; the
// walk register still takes an item until it is also full. Synchronous
// reset clears the counters, the valid flags and the configuration registers
// to their documented reset values. Any configuration write returns the
// counters to the origin, so the next draw starts at the top-left pixel.
//
`default_nettype none

module clipped_color_key_sprite_blitter_unit #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 240
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  ccksb_pixel_if.sink                        pixel,
  ccksb_write_if.source                      fb_write,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ccksb_pkg::PADDR_W-1:0] paddr,
  input  wire logic [ccksb_pkg::PDATA_W-1:0] pwdata,
  output logic      [ccksb_pkg::PDATA_W-1:0] prdata,
  output logic                               pready
);

  // Live configuration and the strobe that rewinds the counters.
  ccksb_pkg::cfg_t  cfg;
  logic             cfg_wr;

  // Step between the position walk and the write stage.
  ccksb_pkg::step_t step;
  logic             step_valid;
  logic             step_ready;

  ccksb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .cfg_wr  (cfg_wr)
  );

  // The walk assigns each accepted item its screen position, the keyed-out
  // flag and the end-of-draw flag, and advances the column and row counters.
  ccksb_walk u_walk (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cfg_wr     (cfg_wr),
    .in_valid   (pixel.valid),
    .in_ready   (pixel.ready),
    .in_pixel   (pixel.src_pixel),
    .step_valid (step_valid),
    .step_ready (step_ready),
    .step       (step)
  );

  // The write stage clips against the screen edges and computes the linear
  // address with a single constant multiply and add.
  ccksb_emit #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_emit (
    .clk           (clk),
    .rst           (rst),
    .step_valid    (step_valid),
    .step_ready    (step_ready),
    .step          (step),
    .out_valid     (fb_write.valid),
    .out_ready     (fb_write.ready),
    .write_enable  (fb_write.write_enable),
    .write_address (fb_write.write_address),
    .write_data    (fb_write.write_data),
    .draw_done     (fb_write.draw_done)
  );

endmodule

`default_nettype wire

@@ hw/rtl/ccksb_checker.sv @@
// ----------------------------------------------------------------------------
// Sprite blitter checker
// Port-level assertions on the blitter, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "clipped_color_key_sprite_blitter_unit_defines.svh"

module ccksb_checker #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 240
) (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic                          write_enable,
  input wire logic [ccksb_pkg::ADDR_W-1:0]  write_address,
  input wire logic [ccksb_pkg::COLOR_W-1:0] write_data,
  input wire logic                          draw_done
);

  // Reset leaves no result pending.
  `CCKSB_ASSERT_IMP_ALWAYS(a_reset_empty, clk, $past(rst), !out_valid, "result valid after reset")

  // A suppressed write carries zero address and zero data.
  `CCKSB_ASSERT_IMP(a_quiet_zero, clk, rst, out_valid && !write_enable, (write_address == '0) && (write_data == '0), "suppressed write has nonzero payload")

  // A real write lands inside the framebuffer.
  `CCKSB_ASSERT_IMP(a_addr_range, clk, rst, out_valid && write_enable, 32'(write_address) < 32'(SCREEN_WIDTH * SCREEN_HEIGHT), "write address beyond framebuffer")

  // A stalled result holds.
  `CCKSB_ASSERT_NEXT(a_stall_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(write_enable) && $stable(write_address) && $stable(write_data) && $stable(draw_done), "stalled result changed")

endmodule

bind clipped_color_key_sprite_blitter_unit ccksb_checker #(
  .SCREEN_WIDTH  (SCREEN_WIDTH),
  .SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_ccksb_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (fb_write.valid),
  .out_ready     (fb_write.ready),
  .write_enable  (fb_write.write_enable),
  .write_address (fb_write.write_address),
  .write_data    (fb_write.write_data),
  .draw_done     (fb_write.draw_done)
);

`default_nettype wire

@@ sim/clipped_color_key_sprite_blitter_unit_test.sv @@
// ----------------------------------------------------------------------------
// Sprite blitter testbench
// Streams sprite pixels and line steps into the blitter under a range of
// register settings, predicts every framebuffer write item in the bench and
// checks each one field by field, with random bursts and output stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module clipped_color_key_sprite_blitter_unit_test;
  import ccksb_pkg::*;

  // The block is built for the usual 320 x 240 screen.
  localparam int SCREEN_W = 320;
  localparam int SCREEN_H = 240;

  // The fourth draw mode has no name in the package; it draws like opaque.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS = 500;
  localparam int TAIL_CYCLES  = 8;
  localparam int PRINT_LIMIT  = 100;

  typedef enum {STALL_NONE, STALL_COIN, STALL_PERIODIC, STALL_LONG} stall_style_t;

  // One framebuffer write item as the block reports it.
  typedef struct packed {
    logic               write_enable;
    logic [ADDR_W-1:0]  write_address;
    logic [COLOR_W-1:0] write_data;
    logic               draw_done;
  } fb_write_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  ccksb_pixel_if pixel_ch();
  ccksb_write_if write_ch();

  clipped_color_key_sprite_blitter_unit #(
    .SCREEN_WIDTH (SCREEN_W),
    .SCREEN_HEIGHT(SCREEN_H)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .pixel   (pixel_ch),
    .fb_write(write_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The bench keeps its own copy of the registers and of the drawing
  // position. The position walks the sprite in row-major order, or along the
  // line, and returns to the origin at the end of a draw or on any write.
  cfg_t             shadow_cfg;
  logic [COL_W-1:0] walk_col;
  logic [ROW_W-1:0] walk_row;

  // Write items that the block still owes, oldest first.
  fb_write_t expected_writes[$];

  int error_count = 0;
  int burst_left;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    if (error_count <= PRINT_LIMIT) begin
      $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    end
  endtask

  // Works out the write item for one accepted pixel and advances the
  // drawing position the way the block does.
  function automatic fb_write_t predict_fb_write(input logic [COLOR_W-1:0] px);
    fb_write_t   w;
    int unsigned col, row, sx, sy, span, cols, rows;
    logic        hit;
    w   = '0;
    col = walk_col;
    row = walk_row;
    sx  = shadow_cfg.origin_x + col;
    if (shadow_cfg.draw_mode == MODE_LINE) begin
      // A line stays on the origin row; the source pixel is ignored.
      span = (shadow_cfg.run_length == '0) ? 1 : shadow_cfg.run_length;
      sy = shadow_cfg.origin_y;
      w.write_data = shadow_cfg.run_color;
      hit = (sx < SCREEN_W) && (sy < SCREEN_H);
      w.draw_done = (col + 1 >= span);
      if (w.draw_done) begin
        walk_col = '0;
      end else begin
        walk_col = COL_W'(col + 1);
      end
      walk_row = '0;
    end else begin
      // Opaque, keyed and the unused mode all walk the sprite. A size of
      // zero counts as one pixel.
      cols = (shadow_cfg.sprite_cols == '0) ? 1 : shadow_cfg.sprite_cols;
      rows = (shadow_cfg.sprite_rows == '0) ? 1 : shadow_cfg.sprite_rows;
      sy = shadow_cfg.origin_y + row;
      w.write_data = px;
      hit = (sx < SCREEN_W) && (sy < SCREEN_H) &&
            !(shadow_cfg.draw_mode == MODE_KEYED && px == shadow_cfg.key_color);
      w.draw_done = (col + 1 >= cols) && (row + 1 >= rows);
      if (col + 1 >= cols) begin
        walk_col = '0;
        if (row + 1 >= rows) begin
          walk_row = '0;
        end else begin
          walk_row = ROW_W'(row + 1);
        end
      end else begin
        walk_col = COL_W'(col + 1);
      end
    end
    // A suppressed write carries zero address and zero data.
    w.write_enable = hit;
    if (hit) begin
      w.write_address = ADDR_W'(sy * SCREEN_W + sx);
    end else begin
      w.write_data = '0;
    end
    return w;
  endfunction

  function automatic void apply_reg_write(input reg_idx_t idx, input logic [PDATA_W-1:0] value);
    case (idx)
      REG_DRAW_MODE:   shadow_cfg.draw_mode   = 2'(value);
      REG_ORIGIN_X:    shadow_cfg.origin_x    = COL_W'(value);
      REG_ORIGIN_Y:    shadow_cfg.origin_y    = ROW_W'(value);
      REG_SPRITE_COLS: shadow_cfg.sprite_cols = COL_W'(value);
      REG_SPRITE_ROWS: shadow_cfg.sprite_rows = ROW_W'(value);
      REG_KEY_COLOR:   shadow_cfg.key_color   = COLOR_W'(value);
      REG_RUN_LENGTH:  shadow_cfg.run_length  = COL_W'(value);
      REG_RUN_COLOR:   shadow_cfg.run_color   = COLOR_W'(value);
      default: ;
    endcase
    walk_col = '0;
    walk_row = '0;
  endfunction

  function automatic logic [PDATA_W-1:0] reg_value(input reg_idx_t idx);
    logic [PDATA_W-1:0] v;
    v = '0;
    case (idx)
      REG_DRAW_MODE:   v = PDATA_W'(shadow_cfg.draw_mode);
      REG_ORIGIN_X:    v = PDATA_W'(shadow_cfg.origin_x);
      REG_ORIGIN_Y:    v = PDATA_W'(shadow_cfg.origin_y);
      REG_SPRITE_COLS: v = PDATA_W'(shadow_cfg.sprite_cols);
      REG_SPRITE_ROWS: v = PDATA_W'(shadow_cfg.sprite_rows);
      REG_KEY_COLOR:   v = PDATA_W'(shadow_cfg.key_color);
      REG_RUN_LENGTH:  v = PDATA_W'(shadow_cfg.run_length);
      REG_RUN_COLOR:   v = PDATA_W'(shadow_cfg.run_color);
      default: ;
    endcase
    return v;
  endfunction

  // Puts random junk in the bits above a field, which the block must drop.
  function automatic logic [PDATA_W-1:0] with_noise(input int unsigned field, input int width);
    logic [PDATA_W-1:0] upper;
    upper = ~((PDATA_W'(1) << width) - 1);
    return (PDATA_W'($urandom()) & upper) | PDATA_W'(field);
  endfunction

  function automatic logic [COLOR_W-1:0] random_pixel();
    case ($urandom_range(0, 7))
      0, 1:    return shadow_cfg.key_color;
      2:       return '0;
      3:       return '1;
      default: return COLOR_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Setup cycle, then access cycle; the register takes the value at the
  // edge that ends the access cycle. The bus then returns to idle.
  task automatic write_reg(input reg_idx_t idx, input logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    apply_reg_write(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_reg(input reg_idx_t idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= PADDR_W'({idx, 2'b00});
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== reg_value(idx)) begin
      report_mismatch($sformatf("%s readback", idx.name()), prdata, reg_value(idx));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Offers one pixel item and waits for it to be taken. The sender works in
  // bursts: valid stays high from one item to the next inside a burst, and
  // a random gap, often none, separates bursts.
  task automatic send_pixel(input logic [COLOR_W-1:0] px);
    int gap;
    pixel_ch.valid     <= 1'b1;
    pixel_ch.src_pixel <= px;
    do @(posedge clk); while (!pixel_ch.ready);
    expected_writes.push_back(predict_fb_write(px));
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 4);
      if (gap > 0) begin
        pixel_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Stops offering items and waits until every owed write has come out.
  // Since every item makes a write, the block is idle after this.
  task automatic wait_for_writes();
    pixel_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_writes.size() != 0);
  endtask

  // Reset values read back, then two pixels through the one-pixel sprite
  // at the top-left corner, with all-zero and all-one colors.
  task automatic test_reset_values();
    reg_idx_t first_reg;
    first_reg = REG_DRAW_MODE;
    for (int i = 0; i < first_reg.num(); i++) begin
      check_reg(reg_idx_t'(i));
    end
    send_pixel(16'h0000);
    send_pixel(16'hFFFF);
    wait_for_writes();
  endtask

  // A 3 x 2 sprite hanging over the bottom-right corner: the last column
  // runs past the right edge and the second row lies below the screen.
  // Clipped pixels are still taken from the stream.
  task automatic test_edge_clipping();
    write_reg(REG_DRAW_MODE, MODE_OPAQUE);
    write_reg(REG_ORIGIN_X, 318);
    write_reg(REG_ORIGIN_Y, 239);
    write_reg(REG_SPRITE_COLS, 3);
    write_reg(REG_SPRITE_ROWS, 2);
    for (int i = 0; i < 6; i++) begin
      send_pixel(COLOR_W'(16'h1230 + i));
    end
    wait_for_writes();
  endtask

  // In keyed mode the key color is dropped and any other color is written.
  task automatic test_color_key();
    write_reg(REG_DRAW_MODE, MODE_KEYED);
    write_reg(REG_ORIGIN_X, 5);
    write_reg(REG_ORIGIN_Y, 6);
    write_reg(REG_SPRITE_COLS, 2);
    write_reg(REG_SPRITE_ROWS, 1);
    write_reg(REG_KEY_COLOR, 16'hA5A5);
    send_pixel(16'hA5A5);
    send_pixel(16'h5A5A);
    wait_for_writes();
  endtask

  // A line clipped at the right edge, then a line entirely below the screen.
  task automatic test_line_runs();
    write_reg(REG_DRAW_MODE, MODE_LINE);
    write_reg(REG_ORIGIN_X, 318);
    write_reg(REG_ORIGIN_Y, 10);
    write_reg(REG_RUN_LENGTH, 3);
    write_reg(REG_RUN_COLOR, 16'hBEEF);
    repeat (3) send_pixel(random_pixel());
    wait_for_writes();
    write_reg(REG_ORIGIN_Y, 255);
    write_reg(REG_RUN_LENGTH, 1);
    send_pixel(16'hFFFF);
    wait_for_writes();
  endtask

  // Sizes of zero act as one, and the unused mode draws like opaque.
  task automatic test_degenerate_sizes();
    write_reg(REG_DRAW_MODE, MODE_OPAQUE);
    write_reg(REG_ORIGIN_X, 0);
    write_reg(REG_ORIGIN_Y, 0);
    write_reg(REG_SPRITE_COLS, 0);
    write_reg(REG_SPRITE_ROWS, 0);
    send_pixel(16'h8001);
    wait_for_writes();
    write_reg(REG_DRAW_MODE, MODE_LINE);
    write_reg(REG_RUN_LENGTH, 0);
    send_pixel(16'h0000);
    wait_for_writes();
    write_reg(REG_DRAW_MODE, MODE_UNUSED);
    write_reg(REG_KEY_COLOR, 16'h7FFE);
    write_reg(REG_SPRITE_COLS, 1);
    write_reg(REG_SPRITE_ROWS, 1);
    send_pixel(16'h7FFE);
    wait_for_writes();
  endtask

  // A write to any register, even one unrelated to the draw, sends the
  // position back to the origin in the middle of a sprite.
  task automatic test_restart_on_write();
    write_reg(REG_DRAW_MODE, MODE_OPAQUE);
    write_reg(REG_ORIGIN_X, 100);
    write_reg(REG_ORIGIN_Y, 100);
    write_reg(REG_SPRITE_COLS, 4);
    write_reg(REG_SPRITE_ROWS, 1);
    send_pixel(16'h0101);
    send_pixel(16'h0202);
    wait_for_writes();
    write_reg(REG_KEY_COLOR, 16'h1111);
    send_pixel(16'h0303);
    wait_for_writes();
  endtask

  // The widest sprite, the tallest sprite and the longest line the fields
  // allow, each drawn to the end so the counters reach their top values.
  task automatic test_large_sizes();
    write_reg(REG_DRAW_MODE, MODE_OPAQUE);
    write_reg(REG_ORIGIN_X, 0);
    write_reg(REG_ORIGIN_Y, 0);
    write_reg(REG_SPRITE_COLS, 511);
    write_reg(REG_SPRITE_ROWS, 1);
    repeat (511) send_pixel(random_pixel());
    wait_for_writes();
    write_reg(REG_SPRITE_COLS, 1);
    write_reg(REG_SPRITE_ROWS, 255);
    repeat (255) send_pixel(random_pixel());
    wait_for_writes();
    write_reg(REG_DRAW_MODE, MODE_LINE);
    write_reg(REG_ORIGIN_Y, 239);
    write_reg(REG_RUN_LENGTH, 511);
    write_reg(REG_RUN_COLOR, 16'hFFFF);
    repeat (511) send_pixel(random_pixel());
    wait_for_writes();
  endtask

  // Random settings, mostly small sprites near the screen edges. Each
  // setting draws a few complete sprites or lines, sometimes followed by a
  // draw that is cut short by the next register write.
  task automatic test_random_draws();
    int          sent, span;
    logic [1:0]  mode;
    int unsigned ox, oy, cols, rows, run;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: mode = MODE_OPAQUE;
        4, 5, 6:    mode = MODE_KEYED;
        7, 8:       mode = MODE_LINE;
        default:    mode = MODE_UNUSED;
      endcase
      case ($urandom_range(0, 3))
        0:       ox = $urandom_range(0, 319);
        1:       ox = $urandom_range(300, 319);
        2:       ox = $urandom_range(320, 511);
        default: ox = $urandom_range(0, 20);
      endcase
      case ($urandom_range(0, 3))
        0:       oy = $urandom_range(0, 239);
        1:       oy = $urandom_range(225, 239);
        2:       oy = $urandom_range(240, 255);
        default: oy = $urandom_range(0, 10);
      endcase
      case ($urandom_range(0, 7))
        0:       cols = 0;
        7:       cols = $urandom_range(13, 40);
        default: cols = $urandom_range(1, 12);
      endcase
      case ($urandom_range(0, 7))
        0:       rows = 0;
        7:       rows = $urandom_range(9, 20);
        default: rows = $urandom_range(1, 8);
      endcase
      case ($urandom_range(0, 7))
        0:       run = 0;
        7:       run = $urandom_range(100, 511);
        default: run = $urandom_range(1, 24);
      endcase
      write_reg(REG_DRAW_MODE, with_noise(mode, $bits(shadow_cfg.draw_mode)));
      write_reg(REG_ORIGIN_X, with_noise(ox, $bits(shadow_cfg.origin_x)));
      write_reg(REG_ORIGIN_Y, with_noise(oy, $bits(shadow_cfg.origin_y)));
      write_reg(REG_SPRITE_COLS, with_noise(cols, $bits(shadow_cfg.sprite_cols)));
      write_reg(REG_SPRITE_ROWS, with_noise(rows, $bits(shadow_cfg.sprite_rows)));
      write_reg(REG_KEY_COLOR,
                with_noise($urandom_range(0, 65535), $bits(shadow_cfg.key_color)));
      write_reg(REG_RUN_LENGTH, with_noise(run, $bits(shadow_cfg.run_length)));
      write_reg(REG_RUN_COLOR,
                with_noise($urandom_range(0, 65535), $bits(shadow_cfg.run_color)));
      check_reg(reg_idx_t'($urandom_range(0, 7)));

      if (shadow_cfg.draw_mode == MODE_LINE) begin
        span = (run == 0) ? 1 : run;
      end else begin
        span = ((cols == 0) ? 1 : cols) * ((rows == 0) ? 1 : rows);
      end
      repeat ($urandom_range(1, 4)) begin
        repeat (span) begin
          send_pixel(random_pixel());
          sent++;
        end
        // Now and then the sender holds off until the block has emptied.
        if ($urandom_range(0, 7) == 0) begin
          wait_for_writes();
        end
      end
      if (span > 1 && $urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, span - 1)) begin
          send_pixel(random_pixel());
          sent++;
        end
      end
      wait_for_writes();
    end
  endtask

  // The receiver changes its manner every so often: always ready, a coin
  // toss per cycle, a fixed one-in-four stall, or rare long stalls.
  initial begin : fb_sink
    stall_style_t style;
    int           style_left, hold_left, beat;
    write_ch.ready <= 1'b0;
    style      = STALL_NONE;
    style_left = 0;
    hold_left  = 0;
    beat       = 0;
    forever begin
      @(posedge clk);
      if (style_left == 0) begin
        style      = stall_style_t'($urandom_range(0, 3));
        style_left = $urandom_range(16, 200);
      end
      style_left--;
      beat++;
      case (style)
        STALL_NONE:     write_ch.ready <= 1'b1;
        STALL_COIN:     write_ch.ready <= 1'($urandom_range(0, 1));
        STALL_PERIODIC: write_ch.ready <= (beat % 4 != 3);
        default: begin
          if (hold_left > 0) begin
            write_ch.ready <= 1'b0;
            hold_left--;
          end else begin
            write_ch.ready <= 1'b1;
            if ($urandom_range(0, 7) == 0) begin
              hold_left = $urandom_range(1, 20);
            end
          end
        end
      endcase
    end
  end

  // Every write item the block hands over is matched against the oldest
  // prediction still waiting.
  always @(posedge clk) begin : write_checker
    fb_write_t want;
    if (!rst && write_ch.valid && write_ch.ready) begin
      if (expected_writes.size() == 0) begin
        report_mismatch("write item with nothing expected", write_ch.write_address, '0);
      end else begin
        want = expected_writes.pop_front();
        if (write_ch.write_enable !== want.write_enable) begin
          report_mismatch("write_enable", write_ch.write_enable, want.write_enable);
        end
        if (write_ch.write_address !== want.write_address) begin
          report_mismatch("write_address", write_ch.write_address, want.write_address);
        end
        if (write_ch.write_data !== want.write_data) begin
          report_mismatch("write_data", write_ch.write_data, want.write_data);
        end
        if (write_ch.draw_done !== want.draw_done) begin
          report_mismatch("draw_done", write_ch.draw_done, want.draw_done);
        end
      end
    end
  end

  // Main sequence: reset once, the directed cases, the large draws, then the
  // random part. At the end the bench waits for every owed write and then
  // watches the idle outputs in case the block sends anything it should not.
  initial begin
    rst                <= 1'b1;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    pixel_ch.valid     <= 1'b0;
    pixel_ch.src_pixel <= '0;
    shadow_cfg             = '0;
    shadow_cfg.sprite_cols = 1;
    shadow_cfg.sprite_rows = 1;
    shadow_cfg.run_length  = 1;
    walk_col   = '0;
    walk_row   = '0;
    burst_left = $urandom_range(1, 40);
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_edge_clipping();
    test_color_key();
    test_line_runs();
    test_degenerate_sizes();
    test_restart_on_write();
    test_large_sizes();
    test_random_draws();

    wait_for_writes();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // The slowest correct run stays far below this.
  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
